// ----- design/pslcd_pkg.sv -----
package pslcd_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int KIND_W     = 2;
  localparam int NODE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 40;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int V_W        = 50;
  localparam int VC_W       = 21;
  localparam int PCT_W      = 24;
  localparam int QUOT_SHIFT = 10;
  localparam int QUOT_W     = PCT_W - QUOT_SHIFT;
  localparam int BYTE_W     = 8;

  // Shared multiplier: signed operand split into a signed high half and an
  // unsigned low half, one partial product per cycle.
  localparam int MUL_A_W    = ACC_W + 1;
  localparam int MUL_P_W    = MUL_A_W + GAIN_W;
  localparam int HALF_W     = MUL_A_W / 2;
  localparam int HI_W       = MUL_A_W - HALF_W;
  localparam int PP_W       = HI_W + GAIN_W + 1;
  localparam int SUM_W      = PP_W + HALF_W;
  localparam int PROD_SH_W  = MUL_P_W - FRAC_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [V_W-1:0]   VOLT_LIMIT = V_W'(12 * 65536);
  localparam logic signed [PCT_W-1:0] PCT_LIMIT  = PCT_W'(99 * 65536);
  localparam logic [PCT_W-1:0]        PCT_OFFSET = PCT_W'(100 * 65536);

  // floor(q / 50) == (q * VOLT_RECIP) >> VOLT_SHIFT for every q below 2^QUOT_W.
  localparam logic [GAIN_W-1:0] VOLT_RECIP = GAIN_W'(20972);
  localparam int                VOLT_SHIFT = 20;

  localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = GAIN_W'(1573);
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = GAIN_W'(52429);
  localparam logic [GAIN_W-1:0] RST_EMF_GAIN   = GAIN_W'(1534);
  localparam logic [GAIN_W-1:0] RST_TIME_STEP  = GAIN_W'(2621);
  localparam logic [GAIN_W-1:0] RST_GEAR_RATIO = GAIN_W'(380109);
  localparam logic [GAIN_W-1:0] RST_PCT_VOLT   = GAIN_W'(563016);

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd2;

  localparam logic [BYTE_W-1:0] CODE_HIGH_FIRST  = 8'h25;
  localparam logic [BYTE_W-1:0] CODE_HIGH_SECOND = 8'h26;
  localparam logic [BYTE_W-1:0] CODE_LOW_FIRST   = 8'h21;
  localparam logic [BYTE_W-1:0] CODE_LOW_SECOND  = 8'h22;
  localparam logic [BYTE_W-1:0] CODE_MODE_FIRST  = 8'h23;
  localparam logic [BYTE_W-1:0] CODE_MODE_SECOND = 8'h24;
  localparam logic [BYTE_W-1:0] CODE_BRAKE       = 8'h1E;
  localparam logic [BYTE_W-1:0] BRAKE_CH_FIRST   = 8'h10;
  localparam logic [BYTE_W-1:0] BRAKE_CH_SECOND  = 8'h20;
  localparam logic [BYTE_W-1:0] MASK_ALL         = 8'hFF;
  localparam logic [BYTE_W-1:0] MODE_VALUE       = 8'h3F;
  localparam logic [BYTE_W-1:0] LOW_BASE         = 8'h80;
  localparam logic [BYTE_W-1:0] BRAKE_ON         = 8'hFF;
  localparam logic [BYTE_W-1:0] BRAKE_OFF        = 8'h00;
  localparam logic [BYTE_W-1:0] VOLT_STOP_LO     = 8'd127;
  localparam logic [BYTE_W-1:0] VOLT_STOP_HI     = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_EMF_GAIN,
    CFG_TIME_STEP,
    CFG_GEAR_RATIO,
    CFG_PCT_VOLT,
    CFG_CARD_KIND,
    CFG_NODE_ID
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_PROP,
    ST_INTEG,
    ST_MEAS,
    ST_EMF,
    ST_CLAMP,
    ST_STEP,
    ST_PCT,
    ST_VOLT,
    ST_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    SLOT_HIGH,
    SLOT_LOW,
    SLOT_MODE,
    SLOT_BRAKE
  } frame_slot_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] emf_gain;
    logic [GAIN_W-1:0] time_step;
    logic [GAIN_W-1:0] gear_ratio;
    logic [GAIN_W-1:0] percent_per_volt;
    logic [KIND_W-1:0] card_kind;
    logic [NODE_W-1:0] node_id;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] volt;
    logic              clamped;
    logic              second;
  } job_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [V_W-1:0] x);
    logic signed [ACC_W-1:0] r;
    if (x > V_W'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (x < V_W'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/pslcd_mul.sv -----
module pslcd_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [pslcd_pkg::MUL_A_W-1:0]  a,
  input  logic        [pslcd_pkg::GAIN_W-1:0]   b,
  output logic                                  done,
  output logic signed [pslcd_pkg::MUL_P_W-1:0]  prod
);
  import pslcd_pkg::*;

  logic                     busy;
  logic [HALF_W-1:0]        a_lo;
  logic [GAIN_W-1:0]        b_q;
  logic signed [PP_W-1:0]   hi_part;
  logic signed [HI_W-1:0]   op_a;
  logic [GAIN_W-1:0]        op_b;
  logic signed [PP_W-1:0]   pp;

  // The high half goes through in the start cycle, the low half in the next cycle.
  always_comb begin
    op_a = busy ? $signed(HI_W'(a_lo)) : a[MUL_A_W-1:HALF_W];
    op_b = busy ? b_q : b;
    pp   = op_a * $signed({1'b0, op_b});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        hi_part <= pp;
        a_lo    <= a[HALF_W-1:0];
        b_q     <= b;
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
        prod <= MUL_P_W'((SUM_W'(hi_part) <<< HALF_W) + SUM_W'(pp));
      end
    end
  end

endmodule

// ----- design/pslcd_front.sv -----
module pslcd_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pslcd_pkg::DATA_W-1:0]  speed_target,
  input  logic signed [pslcd_pkg::DATA_W-1:0]  speed_measured,
  input  pslcd_pkg::cfg_t                      cfg,
  output logic                                 job_valid,
  input  logic                                 job_ready,
  output pslcd_pkg::job_t                      job
);
  import pslcd_pkg::*;

  front_state_t state, state_next;

  logic signed [DATA_W-1:0]    target_q;
  logic signed [DATA_W-1:0]    meas_q;
  logic signed [ACC_W-1:0]     err_w;
  logic signed [ACC_W-1:0]     meas_w;
  logic signed [ACC_W-1:0]     error_sum;
  logic signed [V_W-1:0]       v_acc;
  logic signed [VC_W-1:0]      v_clamp;
  logic                        clamped;
  logic [QUOT_W-1:0]           quot;
  logic [BYTE_W-1:0]           volt;
  logic                        issued;

  logic                        mul_start;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic [GAIN_W-1:0]           mul_b;
  logic                        mul_done;
  logic signed [MUL_P_W-1:0]   mul_prod;
  logic signed [PROD_SH_W-1:0] prod_sh;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [PCT_W-1:0]     pct_c;
  logic [PCT_W:0]              pct_sum;
  logic                        send;

  pslcd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Arithmetic shift of the product is the floor of the Q16 rescale.
  assign prod_sh = mul_prod[MUL_P_W-1:FRAC_W];
  assign diff    = DIFF_W'(target_q) - DIFF_W'(meas_q);
  assign send    = (cfg.card_kind == KIND_FIRST) || (cfg.card_kind == KIND_SECOND);

  always_comb begin
    if (prod_sh > PROD_SH_W'(PCT_LIMIT)) begin
      pct_c = PCT_LIMIT;
    end else if (prod_sh < -PROD_SH_W'(PCT_LIMIT)) begin
      pct_c = -PCT_LIMIT;
    end else begin
      pct_c = prod_sh[PCT_W-1:0];
    end
    // Offset by 100 % so the drive byte becomes floor(pct_sum / 51200).
    pct_sum = (PCT_W+1)'(pct_c) + (PCT_W+1)'(PCT_OFFSET);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ERR;
      ST_ERR:   if (mul_done) state_next = ST_PROP;
      ST_PROP:  if (mul_done) state_next = ST_INTEG;
      ST_INTEG: if (mul_done) state_next = ST_MEAS;
      ST_MEAS:  if (mul_done) state_next = ST_EMF;
      ST_EMF:   if (mul_done) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_STEP;
      ST_STEP:  if (mul_done) state_next = ST_PCT;
      ST_PCT:   if (mul_done) state_next = ST_VOLT;
      ST_VOLT:  if (mul_done) state_next = ST_PUSH;
      ST_PUSH:  if (!send || job_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    job_valid = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ERR: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(diff);
        mul_b     = cfg.gear_ratio;
      end
      ST_PROP: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(err_w);
        mul_b     = cfg.prop_gain;
      end
      ST_INTEG: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(error_sum);
        mul_b     = cfg.integ_gain;
      end
      ST_MEAS: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(meas_q);
        mul_b     = cfg.gear_ratio;
      end
      ST_EMF: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(meas_w);
        mul_b     = cfg.emf_gain;
      end
      ST_CLAMP: begin
      end
      ST_STEP: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(err_w);
        mul_b     = cfg.time_step;
      end
      ST_PCT: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(v_clamp);
        mul_b     = cfg.percent_per_volt;
      end
      ST_VOLT: begin
        mul_start = !issued;
        mul_a     = MUL_A_W'(quot);
        mul_b     = VOLT_RECIP;
      end
      ST_PUSH: begin
        job_valid = send;
      end
      default: begin
      end
    endcase
  end

  assign job.volt    = volt;
  assign job.clamped = clamped;
  assign job.second  = (cfg.card_kind == KIND_SECOND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      error_sum <= '0;
    end else begin
      state <= state_next;
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      // The integrator is cleared on a clamp, otherwise it saturates at its width.
      if (state == ST_STEP && mul_done) begin
        error_sum <= clamped ? '0 : sat_acc(V_W'(error_sum) + V_W'(prod_sh));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      target_q <= speed_target;
      meas_q   <= speed_measured;
    end
    if (state == ST_CLAMP) begin
      if (v_acc > VOLT_LIMIT) begin
        v_clamp <= VC_W'(VOLT_LIMIT);
        clamped <= 1'b1;
      end else if (v_acc < -VOLT_LIMIT) begin
        v_clamp <= -VC_W'(VOLT_LIMIT);
        clamped <= 1'b1;
      end else begin
        v_clamp <= v_acc[VC_W-1:0];
        clamped <= 1'b0;
      end
    end
    if (mul_done) begin
      priority case (state)
        ST_ERR:   err_w  <= sat_acc(V_W'(prod_sh));
        ST_PROP:  v_acc  <= V_W'(prod_sh);
        ST_INTEG: v_acc  <= v_acc + V_W'(prod_sh);
        ST_MEAS:  meas_w <= prod_sh[ACC_W-1:0];
        ST_EMF:   v_acc  <= v_acc + V_W'(prod_sh);
        ST_PCT:   quot   <= pct_sum[PCT_W-1:QUOT_SHIFT];
        ST_VOLT:  volt   <= mul_prod[VOLT_SHIFT+BYTE_W-1:VOLT_SHIFT];
        default: begin
        end
      endcase
    end
  end

  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> issued)
    else $error("multiplier result without an issued product");

  a_clamp_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && mul_done && clamped) |=> (error_sum == '0))
    else $error("integrator not cleared after a clamp");

endmodule

// ----- design/pslcd_queue.sv -----
module pslcd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  pslcd_pkg::job_t   push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pslcd_pkg::job_t   pop_data
);
  import pslcd_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("job queue count past its depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("job queue pointers disagree with an empty count");

endmodule

// ----- design/pslcd_back.sv -----
module pslcd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  pslcd_pkg::job_t                   job,
  input  logic [pslcd_pkg::NODE_W-1:0]      node_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pslcd_pkg::NODE_W-1:0]      frame_id,
  output logic [pslcd_pkg::BYTE_W-1:0]      byte_zero,
  output logic [pslcd_pkg::BYTE_W-1:0]      byte_one,
  output logic [pslcd_pkg::BYTE_W-1:0]      byte_two,
  output logic                              was_clamped,
  output logic                              final_frame
);
  import pslcd_pkg::*;

  job_t              cur;
  logic              active;
  frame_slot_t       slot;
  logic              load;
  logic [BYTE_W-1:0] b0;
  logic [BYTE_W-1:0] b1;
  logic [BYTE_W-1:0] b2;
  logic              stop;

  assign job_ready = !active;
  assign load      = active && (!out_valid || out_ready);
  assign stop      = (cur.volt == VOLT_STOP_LO) || (cur.volt == VOLT_STOP_HI);

  always_comb begin
    unique case (slot)
      SLOT_HIGH: begin
        b0 = cur.second ? CODE_HIGH_SECOND : CODE_HIGH_FIRST;
        b1 = MASK_ALL;
        b2 = {2'b00, cur.volt[BYTE_W-1:2]};
      end
      SLOT_LOW: begin
        b0 = cur.second ? CODE_LOW_SECOND : CODE_LOW_FIRST;
        b1 = MASK_ALL;
        b2 = LOW_BASE + BYTE_W'(cur.volt[1:0]);
      end
      SLOT_MODE: begin
        b0 = cur.second ? CODE_MODE_SECOND : CODE_MODE_FIRST;
        b1 = MASK_ALL;
        b2 = MODE_VALUE;
      end
      SLOT_BRAKE: begin
        b0 = CODE_BRAKE;
        b1 = cur.second ? BRAKE_CH_SECOND : BRAKE_CH_FIRST;
        b2 = stop ? BRAKE_ON : BRAKE_OFF;
      end
      default: begin
        b0 = CODE_BRAKE;
        b1 = MASK_ALL;
        b2 = BRAKE_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      slot      <= SLOT_HIGH;
      out_valid <= 1'b0;
    end else begin
      if (!active && job_valid) begin
        active <= 1'b1;
        slot   <= SLOT_HIGH;
      end else if (load) begin
        slot <= frame_slot_t'(slot + 1'b1);
        if (slot == SLOT_BRAKE) begin
          active <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!active && job_valid) begin
      cur <= job;
    end
    if (load) begin
      frame_id    <= node_id;
      byte_zero   <= b0;
      byte_one    <= b1;
      byte_two    <= b2;
      was_clamped <= cur.clamped;
      final_frame <= (slot == SLOT_BRAKE);
    end
  end

  a_brake_last: assert property (@(posedge clk) disable iff (rst)
    (load && slot == SLOT_BRAKE) |=> (out_valid && final_frame && !active))
    else $error("brake frame did not close the tick");

endmodule

// ----- design/pi_speed_loop_can_drive_core.sv -----
// Channel  Handshake             Payload
// in       in_valid / in_ready   speed_target, speed_measured
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
// out      out_valid / out_ready frame_id, byte_zero, byte_one, byte_two,
//                                was_clamped, final_frame
//
// A tick runs from acceptance until its frame job is queued: eight products
// through the shared multiplier, one clamp step and one queue hand-off; the
// next tick is accepted in the idle state after that. A full job queue holds
// the front in its hand-off state. Frames leave the output register at up to
// one per cycle while out_ready is high, four per tick for card kinds 1 and 2,
// none otherwise.
// Synchronous reset clears the integrator, empties the queue and restores
// register defaults; cfg_ready is always high.
module pi_speed_loop_can_drive_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pslcd_pkg::DATA_W-1:0]  speed_target,
  input  logic signed [pslcd_pkg::DATA_W-1:0]  speed_measured,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pslcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pslcd_pkg::GAIN_W-1:0]         cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pslcd_pkg::NODE_W-1:0]         frame_id,
  output logic [pslcd_pkg::BYTE_W-1:0]         byte_zero,
  output logic [pslcd_pkg::BYTE_W-1:0]         byte_one,
  output logic [pslcd_pkg::BYTE_W-1:0]         byte_two,
  output logic                                 was_clamped,
  output logic                                 final_frame
);
  import pslcd_pkg::*;

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= RST_PROP_GAIN;
      cfg.integ_gain       <= RST_INTEG_GAIN;
      cfg.emf_gain         <= RST_EMF_GAIN;
      cfg.time_step        <= RST_TIME_STEP;
      cfg.gear_ratio       <= RST_GEAR_RATIO;
      cfg.percent_per_volt <= RST_PCT_VOLT;
      cfg.card_kind        <= KIND_NONE;
      cfg.node_id          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PROP_GAIN:  cfg.prop_gain        <= cfg_data;
        CFG_INTEG_GAIN: cfg.integ_gain       <= cfg_data;
        CFG_EMF_GAIN:   cfg.emf_gain         <= cfg_data;
        CFG_TIME_STEP:  cfg.time_step        <= cfg_data;
        CFG_GEAR_RATIO: cfg.gear_ratio       <= cfg_data;
        CFG_PCT_VOLT:   cfg.percent_per_volt <= cfg_data;
        CFG_CARD_KIND:  cfg.card_kind        <= cfg_data[KIND_W-1:0];
        CFG_NODE_ID:    cfg.node_id          <= cfg_data[NODE_W-1:0];
      endcase
    end
  end

  pslcd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .speed_target   (speed_target),
    .speed_measured (speed_measured),
    .cfg            (cfg),
    .job_valid      (push_valid),
    .job_ready      (push_ready),
    .job            (push_data)
  );

  pslcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pslcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (pop_valid),
    .job_ready   (pop_ready),
    .job         (pop_data),
    .node_id     (cfg.node_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_id    (frame_id),
    .byte_zero   (byte_zero),
    .byte_one    (byte_one),
    .byte_two    (byte_two),
    .was_clamped (was_clamped),
    .final_frame (final_frame)
  );

endmodule

// ----- dv/tb_pi_speed_loop_can_drive_core.sv -----
module tb_pi_speed_loop_can_drive_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pslcd_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
    bit                       hold;
  } tick_t;

  typedef struct packed {
    logic [NODE_W-1:0] id;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic              clamped;
    logic              last;
  } drive_frame_t;

  localparam wide_t ONE_Q      = 65536;
  localparam wide_t VOLT_CAP   = 12 * 65536;
  localparam wide_t PCT_CAP    = 99 * 65536;
  localparam wide_t DRIVE_MID  = 128 * 100 * 65536;
  localparam wide_t DRIVE_DIV  = 100 * 65536;
  localparam wide_t ACC_TOP    = 96'sh7F_FFFF_FFFF;
  localparam wide_t ACC_BOTTOM = -ACC_TOP - 1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_TICKS   = 25;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] speed_target = '0;
  logic signed [DATA_W-1:0] speed_measured = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [GAIN_W-1:0]        cfg_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [NODE_W-1:0]        frame_id;
  logic [BYTE_W-1:0]        byte_zero;
  logic [BYTE_W-1:0]        byte_one;
  logic [BYTE_W-1:0]        byte_two;
  logic                     was_clamped;
  logic                     final_frame;

  tick_t        ticks_pending[$];
  drive_frame_t frames_due[$];
  tick_t        next_tick;
  drive_frame_t want;
  drive_frame_t seen;
  cfg_t         loop_cfg;
  wide_t        integ_model;
  int           ticks_queued = 0;
  int           ticks_accepted = 0;
  int           frames_outstanding = 0;
  int           mismatch_count = 0;
  int           send_wait = 0;
  int           recv_wait = 0;
  int           stall_draw;
  int           in_gap_max = 0;
  int           out_stall_max = 0;
  int           idle_cycles = 0;

  pi_speed_loop_can_drive_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .speed_target   (speed_target),
    .speed_measured (speed_measured),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_id       (frame_id),
    .byte_zero      (byte_zero),
    .byte_one       (byte_one),
    .byte_two       (byte_two),
    .was_clamped    (was_clamped),
    .final_frame    (final_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic wide_t floor_q(input wide_t x);
    return x >>> FRAC_W;
  endfunction

  function automatic wide_t clip40(input wide_t x);
    if (x > ACC_TOP) begin
      return ACC_TOP;
    end
    if (x < ACC_BOTTOM) begin
      return ACC_BOTTOM;
    end
    return x;
  endfunction

  function automatic wide_t gain_w(input logic [GAIN_W-1:0] g);
    return wide_t'({1'b0, g});
  endfunction

  // Runs one control tick on the local copy of the loop and queues the CAN
  // frames that the card should receive for it.
  function automatic void predict_drive_frames(input logic signed [DATA_W-1:0] tgt,
                                               input logic signed [DATA_W-1:0] meas);
    wide_t        t;
    wide_t        m;
    wide_t        err_w;
    wide_t        v;
    wide_t        pct;
    wide_t        scaled;
    logic         clamped;
    logic         second;
    logic [7:0]   volt;
    drive_frame_t f;
    t = tgt;
    m = meas;
    err_w = clip40(floor_q((t - m) * gain_w(loop_cfg.gear_ratio)));
    v = floor_q(err_w * gain_w(loop_cfg.prop_gain))
      + floor_q(integ_model * gain_w(loop_cfg.integ_gain))
      + floor_q(floor_q(m * gain_w(loop_cfg.gear_ratio)) * gain_w(loop_cfg.emf_gain));
    clamped = 1'b0;
    if (v < -VOLT_CAP) begin
      v = -VOLT_CAP;
      clamped = 1'b1;
    end else if (v > VOLT_CAP) begin
      v = VOLT_CAP;
      clamped = 1'b1;
    end
    if (clamped) begin
      integ_model = '0;
    end else begin
      integ_model = clip40(integ_model + floor_q(err_w * gain_w(loop_cfg.time_step)));
    end
    pct = floor_q(v * gain_w(loop_cfg.percent_per_volt));
    if (pct > PCT_CAP) begin
      pct = PCT_CAP;
    end else if (pct < -PCT_CAP) begin
      pct = -PCT_CAP;
    end
    // The numerator stays positive, so the division is a plain floor.
    scaled = (DRIVE_MID + 128 * pct) / DRIVE_DIV;
    volt = scaled[7:0];
    if (loop_cfg.card_kind == KIND_FIRST || loop_cfg.card_kind == KIND_SECOND) begin
      second = (loop_cfg.card_kind == KIND_SECOND);
      f.id = loop_cfg.node_id;
      f.clamped = clamped;
      f.last = 1'b0;
      f.b1 = MASK_ALL;
      f.b0 = second ? CODE_HIGH_SECOND : CODE_HIGH_FIRST;
      f.b2 = {2'b00, volt[7:2]};
      frames_due.push_back(f);
      f.b0 = second ? CODE_LOW_SECOND : CODE_LOW_FIRST;
      f.b2 = LOW_BASE + BYTE_W'(volt[1:0]);
      frames_due.push_back(f);
      f.b0 = second ? CODE_MODE_SECOND : CODE_MODE_FIRST;
      f.b2 = MODE_VALUE;
      frames_due.push_back(f);
      f.b0 = CODE_BRAKE;
      f.b1 = second ? BRAKE_CH_SECOND : BRAKE_CH_FIRST;
      f.b2 = (volt == VOLT_STOP_LO || volt == VOLT_STOP_HI) ? BRAKE_ON : BRAKE_OFF;
      f.last = 1'b1;
      frames_due.push_back(f);
    end
  endfunction

  // Tick driver: one gap per tick, and a held tick waits for every frame.
  // A tick taken at this very edge is not yet counted in frames_outstanding,
  // so a held tick also waits out that edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_valid <= 1'b0;
      end else if (ticks_pending.size() != 0 &&
                   !(ticks_pending[0].hold && (frames_outstanding != 0 || in_valid))) begin
        next_tick = ticks_pending.pop_front();
        in_valid <= 1'b1;
        speed_target <= next_tick.target;
        speed_measured <= next_tick.measured;
        send_wait <= $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes, predicts at each tick transfer and
  // checks each frame transfer against the oldest expected frame.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      ticks_accepted <= 0;
      frames_outstanding <= 0;
      loop_cfg.prop_gain = RST_PROP_GAIN;
      loop_cfg.integ_gain = RST_INTEG_GAIN;
      loop_cfg.emf_gain = RST_EMF_GAIN;
      loop_cfg.time_step = RST_TIME_STEP;
      loop_cfg.gear_ratio = RST_GEAR_RATIO;
      loop_cfg.percent_per_volt = RST_PCT_VOLT;
      loop_cfg.card_kind = KIND_NONE;
      loop_cfg.node_id = '0;
      integ_model = '0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_PROP_GAIN:  loop_cfg.prop_gain = cfg_data;
          CFG_INTEG_GAIN: loop_cfg.integ_gain = cfg_data;
          CFG_EMF_GAIN:   loop_cfg.emf_gain = cfg_data;
          CFG_TIME_STEP:  loop_cfg.time_step = cfg_data;
          CFG_GEAR_RATIO: loop_cfg.gear_ratio = cfg_data;
          CFG_PCT_VOLT:   loop_cfg.percent_per_volt = cfg_data;
          CFG_CARD_KIND:  loop_cfg.card_kind = cfg_data[KIND_W-1:0];
          CFG_NODE_ID:    loop_cfg.node_id = cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen.id = frame_id;
        seen.b0 = byte_zero;
        seen.b1 = byte_one;
        seen.b2 = byte_two;
        seen.clamped = was_clamped;
        seen.last = final_frame;
        if (frames_due.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected frame id=%h bytes=%h %h %h clamp=%b last=%b",
                     $realtime, seen.id, seen.b0, seen.b1, seen.b2, seen.clamped, seen.last);
          end
        end else begin
          want = frames_due.pop_front();
          if (seen !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("%0t: frame mismatch, expected id=%h bytes=%h %h %h clamp=%b last=%b",
                       $realtime, want.id, want.b0, want.b1, want.b2, want.clamped, want.last);
              $display("%0t:                 actual   id=%h bytes=%h %h %h clamp=%b last=%b",
                       $realtime, seen.id, seen.b0, seen.b1, seen.b2, seen.clamped, seen.last);
            end
          end
        end
        stall_draw = $urandom_range(0, out_stall_max);
        recv_wait <= stall_draw;
        out_ready <= (stall_draw == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= (recv_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_drive_frames(speed_target, speed_measured);
        ticks_accepted <= ticks_accepted + 1;
      end
      frames_outstanding <= frames_due.size();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("pi_speed_loop_can_drive_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a rising edge; leaves the write channel idle at a rising edge.
  task automatic program_regs(input cfg_t c, input logic [7:0] mask);
    logic [GAIN_W-1:0] data;
    cfg_index_t        idx;
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        idx = cfg_index_t'(i);
        case (idx)
          CFG_PROP_GAIN:  data = c.prop_gain;
          CFG_INTEG_GAIN: data = c.integ_gain;
          CFG_EMF_GAIN:   data = c.emf_gain;
          CFG_TIME_STEP:  data = c.time_step;
          CFG_GEAR_RATIO: data = c.gear_ratio;
          CFG_PCT_VOLT:   data = c.percent_per_volt;
          CFG_CARD_KIND:  data = {22'($urandom), c.card_kind};
          default:        data = {13'($urandom), c.node_id};
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_tick(input logic signed [DATA_W-1:0] tgt,
                            input logic signed [DATA_W-1:0] meas, input bit hold);
    tick_t t;
    t.target = tgt;
    t.measured = meas;
    t.hold = hold;
    ticks_pending.push_back(t);
    ticks_queued = ticks_queued + 1;
  endtask

  // Waits for every tick and frame, then long enough for a silent tick to
  // leave the arithmetic pipeline before the registers may change.
  task automatic finish_batch();
    while (ticks_accepted != ticks_queued) @(posedge clk);
    while (frames_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 8;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] nominal);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom);
      4, 5: return GAIN_W'($urandom_range(0, 2 * nominal));
      default: return nominal;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    case ($urandom_range(0, 9))
      0: return KIND_NONE;
      1: return KIND_UNUSED;
      2, 3, 4, 5: return KIND_FIRST;
      default: return KIND_SECOND;
    endcase
  endfunction

  // Mostly a wheel tracking its setpoint, so the integrator builds up over
  // the run; the rest are wide moves and raw noise.
  function automatic tick_t random_tick(input logic signed [DATA_W-1:0] setpoint);
    tick_t t;
    t.hold = 1'b0;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        t.target = $urandom;
        t.measured = $urandom;
      end
      3, 4, 5, 6: begin
        t.target = $signed($urandom) >>> 7;
        t.measured = $signed($urandom) >>> 7;
      end
      default: begin
        t.target = setpoint;
        t.measured = setpoint + ($signed($urandom) >>> $urandom_range(13, 27));
      end
    endcase
    return t;
  endfunction

  initial begin
    cfg_t                     setup;
    tick_t                    t;
    logic signed [DATA_W-1:0] setpoint;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default gains on the first channel: brake band, extremes, huge errors.
    setup.prop_gain = RST_PROP_GAIN;
    setup.integ_gain = RST_INTEG_GAIN;
    setup.emf_gain = RST_EMF_GAIN;
    setup.time_step = RST_TIME_STEP;
    setup.gear_ratio = RST_GEAR_RATIO;
    setup.percent_per_volt = RST_PCT_VOLT;
    setup.card_kind = KIND_FIRST;
    setup.node_id = 11'h7FF;
    program_regs(setup, 8'hFF);
    @(negedge clk);
    in_gap_max = 0;
    out_stall_max = 0;
    queue_tick(32'sd0, 32'sd0, 1'b0);
    queue_tick(32'sd0, -32'sd1, 1'b0);
    queue_tick(32'sd0, 32'sd1, 1'b0);
    queue_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    queue_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    queue_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    queue_tick(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    queue_tick(32'sh0001_0000, 32'sd0, 1'b0);
    finish_batch();

    // Every gain at full scale on the second channel.
    setup.prop_gain = '1;
    setup.integ_gain = '1;
    setup.emf_gain = '1;
    setup.time_step = '1;
    setup.gear_ratio = '1;
    setup.percent_per_volt = '1;
    setup.card_kind = KIND_SECOND;
    setup.node_id = 11'h400;
    program_regs(setup, 8'hFF);
    @(negedge clk);
    in_gap_max = 8;
    out_stall_max = 8;
    queue_tick(32'sh0001_0000, 32'sd0, 1'b0);
    queue_tick(-32'sh0001_0000, 32'sd0, 1'b0);
    queue_tick(32'sd0, 32'sd0, 1'b0);
    finish_batch();

    // Zero output law so the integrator runs into both saturation limits.
    setup.prop_gain = '0;
    setup.integ_gain = '0;
    setup.emf_gain = '0;
    setup.card_kind = KIND_FIRST;
    setup.node_id = 11'h000;
    program_regs(setup, 8'hC7);
    @(negedge clk);
    queue_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    queue_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    queue_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    queue_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    finish_batch();

    // Silent card, then the unused kind, with a saturated integrator.
    setup.integ_gain = 24'd1;
    setup.card_kind = KIND_NONE;
    program_regs(setup, 8'h42);
    @(negedge clk);
    in_gap_max = 3;
    out_stall_max = 0;
    queue_tick(32'sd1, 32'sd0, 1'b0);
    queue_tick(32'sd0, 32'sd0, 1'b0);
    finish_batch();
    setup.card_kind = KIND_UNUSED;
    program_regs(setup, 8'h40);
    @(negedge clk);
    queue_tick(32'sh0100_0000, 32'sd0, 1'b0);
    queue_tick(32'sd0, 32'sh0100_0000, 1'b0);
    finish_batch();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      setup.prop_gain = pick_gain(RST_PROP_GAIN);
      setup.integ_gain = pick_gain(RST_INTEG_GAIN);
      setup.emf_gain = pick_gain(RST_EMF_GAIN);
      setup.time_step = pick_gain(RST_TIME_STEP);
      setup.gear_ratio = pick_gain(RST_GEAR_RATIO);
      setup.percent_per_volt = pick_gain(RST_PCT_VOLT);
      setup.card_kind = pick_kind();
      setup.node_id = NODE_W'($urandom);
      program_regs(setup, 8'($urandom));
      @(negedge clk);
      in_gap_max = pick_idle();
      out_stall_max = pick_idle();
      setpoint = $signed($urandom) >>> $urandom_range(9, 31);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        t = random_tick(setpoint);
        t.hold = ($urandom_range(0, 29) == 0);
        queue_tick(t.target, t.measured, t.hold);
      end
      finish_batch();
    end

    if (mismatch_count == 0 && frames_outstanding == 0) begin
      $display("pi_speed_loop_can_drive_core test passed");
    end else begin
      $display("pi_speed_loop_can_drive_core test failed");
    end
    $finish;
  end

endmodule
